FILE: rtl/assert_macros.svh
// Assertion macros for the image downscaler, clocked on aclk with reset held off.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLD(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`define ASSERT_SAME(label, ante, cons, msg)
`endif
`endif

FILE: rtl/imgds_pkg.sv
// Shared constants and codes for the image downscaler.
package imgds_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd3;

    // Kernel selection for one result word.
    localparam logic [1:0] KSEL_BOX_LOW = 2'd0;  // 2x2 over rows y-1 and y
    localparam logic [1:0] KSEL_BOX_UP  = 2'd1;  // 2x2 over rows y-2 and y-1
    localparam logic [1:0] KSEL_K33     = 2'd2;  // 3x3 weighted kernel
    localparam logic [1:0] KSEL_K23     = 2'd3;  // 2x3 kernel of the last row

    localparam int HEIGHT_LIMIT   = 2048;
    localparam int HEIGHT_RESET   = 480;
    localparam int WIDTH_RESET    = 640;
    localparam int CHANNELS_RESET = 3;

    localparam logic [11:0] K33_CENTER = 12'd5;
    localparam logic [11:0] K23_CENTER = 12'd3;

    // Output queue depth: covers one word in flight plus a stalled sink.
    localparam int OUT_DEPTH = 3;

endpackage

FILE: rtl/image_downscale_by_two.sv
// Half-size image decimation: one input word per cycle when the sink keeps up.
// An accepted word passes the second-stage registers and then the output queue before m_valid shows it.
// Throughput: one sample per clock while s_ready stays high, set by the line store read-modify-write,
// which reads one entry at acceptance and writes it back in the following cycle.
// Reset (aresetn low, synchronous) restores the register defaults, clears counters,
// window and output queue; the line store itself is not cleared.
module image_downscale_by_two #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_scaled_sample,
    output logic        m_frame_last,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

`include "assert_macros.svh"

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int KW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int W_RESET = (imgds_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                  : imgds_pkg::WIDTH_RESET;
    localparam int C_RESET = (imgds_pkg::CHANNELS_RESET > MAX_CHANNELS) ? MAX_CHANNELS
                                                                        : imgds_pkg::CHANNELS_RESET;

    // Configuration, kept already clamped.
    logic          mode_reg;
    logic [WW-1:0] width_reg;
    logic [11:0]   height_reg;
    logic [2:0]    chans_reg;

    // Frame position.
    logic [10:0]   row_reg, row_next;
    logic [XW-1:0] col_reg, col_next;
    logic [KW-1:0] chan_reg, chan_next;
    logic [AW-1:0] idx_reg, idx_next;

    // Line store: upper byte is row y-2, lower byte is row y-1.
    logic [15:0]   line_store_reg [STORE_DEPTH];
    logic [15:0]   rd_data_reg;

    // Second stage.
    logic          st1_valid_reg;
    logic          st1_emit_reg;
    logic          st1_last_reg;
    logic [1:0]    st1_ksel_reg;
    logic [KW-1:0] st1_chan_reg;
    logic [AW-1:0] st1_idx_reg;
    logic [7:0]    st1_sample_reg;

    // Window: two previous pixels of each of the three rows, per channel.
    logic [7:0] win_u1_reg [MAX_CHANNELS];
    logic [7:0] win_u2_reg [MAX_CHANNELS];
    logic [7:0] win_l1_reg [MAX_CHANNELS];
    logic [7:0] win_l2_reg [MAX_CHANNELS];
    logic [7:0] win_s1_reg [MAX_CHANNELS];
    logic [7:0] win_s2_reg [MAX_CHANNELS];

    // Output queue.
    logic [8:0] outq_reg [imgds_pkg::OUT_DEPTH];
    logic [1:0] outq_wr_reg, outq_rd_reg, outq_cnt_reg;

    logic accept, push, pop;
    logic row_odd, col_odd, last_chan, last_col, last_row;
    logic emit0, last0;
    logic [1:0] ksel0;
    logic [WW-1:0] col_ext;
    logic [11:0]   row_ext;
    logic [7:0] a, b, u1, u2, l1, l2, s1, s2, s, result;
    logic [11:0] sum_k33, sum_k23, sum_box_low, sum_box_up;

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;
    assign push   = st1_valid_reg && st1_emit_reg;

    // Room is counted for the word now in the second stage as well.
    assign s_ready = ({1'b0, outq_cnt_reg} + {2'b00, st1_valid_reg})
                     < 3'(imgds_pkg::OUT_DEPTH);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            width_reg  <= WW'(W_RESET);
            height_reg <= 12'(imgds_pkg::HEIGHT_RESET);
            chans_reg  <= 3'(C_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                imgds_pkg::CFG_FILTER_MODE: begin
                    mode_reg <= cfg_data[0];
                end
                imgds_pkg::CFG_IMAGE_WIDTH: begin
                    if (cfg_data < 12'd2)
                        width_reg <= WW'(2);
                    else if (int'(cfg_data) > MAX_WIDTH)
                        width_reg <= WW'(MAX_WIDTH);
                    else
                        width_reg <= WW'(cfg_data);
                end
                imgds_pkg::CFG_IMAGE_HEIGHT: begin
                    if (cfg_data < 12'd2)
                        height_reg <= 12'd2;
                    else if (int'(cfg_data) > imgds_pkg::HEIGHT_LIMIT)
                        height_reg <= 12'(imgds_pkg::HEIGHT_LIMIT);
                    else
                        height_reg <= cfg_data;
                end
                imgds_pkg::CFG_CHANNEL_COUNT: begin
                    if (cfg_data[2:0] == 3'd0)
                        chans_reg <= 3'd1;
                    else if (int'(cfg_data[2:0]) > MAX_CHANNELS)
                        chans_reg <= 3'(MAX_CHANNELS);
                    else
                        chans_reg <= cfg_data[2:0];
                end
                default: begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    // Position decode for the word being accepted.
    always_comb begin
        col_ext   = WW'(col_reg);
        row_ext   = {1'b0, row_reg};
        row_odd   = row_reg[0];
        col_odd   = col_reg[0];
        last_chan = {{(3 - KW){1'b0}}, chan_reg} == (chans_reg - 3'd1);
        last_col  = col_ext == (width_reg - WW'(1));
        last_row  = row_ext == (height_reg - 12'd1);
        emit0     = 1'b0;
        last0     = 1'b0;
        ksel0     = imgds_pkg::KSEL_BOX_LOW;
        if (!mode_reg) begin
            if (row_odd && col_odd) begin
                emit0 = 1'b1;
                // The last emitting row and column skip an odd trailing line.
                last0 = last_chan
                        && (row_ext == (height_reg[0] ? height_reg - 12'd2 : height_reg - 12'd1))
                        && (col_ext == (width_reg[0] ? width_reg - WW'(2) : width_reg - WW'(1)));
            end
        end else begin
            if (!row_odd && row_reg >= 11'd2) begin
                if (!col_odd && col_reg >= XW'(2)) begin
                    emit0 = 1'b1;
                    ksel0 = imgds_pkg::KSEL_K33;
                end else if (!width_reg[0] && last_col) begin
                    emit0 = 1'b1;
                    ksel0 = imgds_pkg::KSEL_BOX_UP;
                end
            end else if (row_odd && last_row) begin
                if (!col_odd && col_reg >= XW'(2)) begin
                    emit0 = 1'b1;
                    ksel0 = imgds_pkg::KSEL_K23;
                end else if (!width_reg[0] && last_col) begin
                    emit0 = 1'b1;
                    ksel0 = imgds_pkg::KSEL_BOX_LOW;
                end
            end
            last0 = emit0 && last_row && last_col && last_chan;
        end
    end

    // Frame counters; the store index runs along the row across channels.
    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        chan_next = chan_reg;
        idx_next  = idx_reg;
        if (cfg_wr_en) begin
            row_next  = '0;
            col_next  = '0;
            chan_next = '0;
            idx_next  = '0;
        end else if (accept) begin
            if (last_chan) begin
                chan_next = '0;
                if (last_col) begin
                    col_next = '0;
                    idx_next = '0;
                    row_next = last_row ? 11'd0 : row_reg + 11'd1;
                end else begin
                    col_next = col_reg + XW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end else begin
                chan_next = chan_reg + KW'(1);
                idx_next  = idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            chan_reg <= '0;
            idx_reg  <= '0;
        end else begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            chan_reg <= chan_next;
            idx_reg  <= idx_next;
        end
    end

    // Line store: read at acceptance, written back in the next cycle. Consecutive
    // words never share an entry since a row holds at least two words.
    always_ff @(posedge aclk) begin
        if (accept)
            rd_data_reg <= line_store_reg[idx_reg];
        if (st1_valid_reg)
            line_store_reg[st1_idx_reg] <= {b, s};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            st1_valid_reg <= 1'b0;
        else
            st1_valid_reg <= accept;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_emit_reg   <= emit0;
            st1_last_reg   <= last0;
            st1_ksel_reg   <= ksel0;
            st1_chan_reg   <= chan_reg;
            st1_idx_reg    <= idx_reg;
            st1_sample_reg <= s_pixel_sample;
        end
    end

    // Kernel arithmetic in the second stage.
    always_comb begin
        a  = rd_data_reg[15:8];
        b  = rd_data_reg[7:0];
        s  = st1_sample_reg;
        u1 = win_u1_reg[st1_chan_reg];
        u2 = win_u2_reg[st1_chan_reg];
        l1 = win_l1_reg[st1_chan_reg];
        l2 = win_l2_reg[st1_chan_reg];
        s1 = win_s1_reg[st1_chan_reg];
        s2 = win_s2_reg[st1_chan_reg];
        sum_k33 = 12'(u2) + 12'(u1) + 12'(a) + 12'(l2) + imgds_pkg::K33_CENTER * 12'(l1)
                  + {3'b000, b, 1'b0} + 12'(s2) + {3'b000, s1, 1'b0} + {3'b000, s, 1'b0};
        sum_k23 = 12'(l2) + 12'(l1) + 12'(b) + 12'(s2) + imgds_pkg::K23_CENTER * 12'(s1)
                  + 12'(s);
        sum_box_low = 12'(l1) + 12'(b) + 12'(s1) + 12'(s);
        sum_box_up  = 12'(u1) + 12'(a) + 12'(l1) + 12'(b);
        case (st1_ksel_reg)
            imgds_pkg::KSEL_BOX_LOW: result = sum_box_low[9:2];
            imgds_pkg::KSEL_BOX_UP:  result = sum_box_up[9:2];
            imgds_pkg::KSEL_K33:     result = sum_k33[11:4];
            imgds_pkg::KSEL_K23:     result = sum_k23[10:3];
            default:                 result = sum_box_low[9:2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                win_u1_reg[i] <= '0;
                win_u2_reg[i] <= '0;
                win_l1_reg[i] <= '0;
                win_l2_reg[i] <= '0;
                win_s1_reg[i] <= '0;
                win_s2_reg[i] <= '0;
            end
        end else if (st1_valid_reg) begin
            win_u2_reg[st1_chan_reg] <= u1;
            win_u1_reg[st1_chan_reg] <= a;
            win_l2_reg[st1_chan_reg] <= l1;
            win_l1_reg[st1_chan_reg] <= b;
            win_s2_reg[st1_chan_reg] <= s1;
            win_s1_reg[st1_chan_reg] <= s;
        end
    end

    // Output queue.
    always_ff @(posedge aclk) begin
        if (push)
            outq_reg[outq_wr_reg] <= {st1_last_reg, result};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outq_wr_reg  <= '0;
            outq_rd_reg  <= '0;
            outq_cnt_reg <= '0;
        end else begin
            if (push)
                outq_wr_reg <= (outq_wr_reg == 2'(imgds_pkg::OUT_DEPTH - 1)) ? 2'd0
                                                                            : outq_wr_reg + 2'd1;
            if (pop)
                outq_rd_reg <= (outq_rd_reg == 2'(imgds_pkg::OUT_DEPTH - 1)) ? 2'd0
                                                                            : outq_rd_reg + 2'd1;
            outq_cnt_reg <= outq_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_valid         = outq_cnt_reg != 2'd0;
    assign m_scaled_sample = outq_reg[outq_rd_reg][7:0];
    assign m_frame_last    = outq_reg[outq_rd_reg][8];

    `ASSERT_HOLD(a_outq_no_overflow, !(push && !pop && outq_cnt_reg == 2'(imgds_pkg::OUT_DEPTH)), "output queue overflow")
    `ASSERT_NEXT(a_accept_to_stage, accept, st1_valid_reg, "accepted word missing from second stage")
    `ASSERT_SAME(a_no_store_hazard, accept && st1_valid_reg, idx_reg != st1_idx_reg, "line store read meets write of the same entry")

endmodule
